/* hdl/lpfe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfe_pkg
// Shared types and constants of the length-prefixed frame extractor.
// ----------------------------------------------------------------------------
package lpfe_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_W     = 17;
    localparam int HDR_LEN   = 15;
    localparam int HDR_CNT_W = 4;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    localparam logic [CFG_W-1:0] MAX_LEN_RESET = 17'd65536;

    localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

    // Register index of the length limit (taken from paddr[2]).
    localparam logic REG_MAX_LEN = 1'b0;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              first_byte;
        logic              last_byte;
    } lpfe_result_t;

    // Fixed header text, one character per index.
    function automatic logic [BYTE_W-1:0] hdr_char(input logic [HDR_CNT_W-1:0] idx);
        logic [BYTE_W-1:0] c;
        begin
            case (idx)
                4'd0:    c = 8'h6D; // m
                4'd1:    c = 8'h65; // e
                4'd2:    c = 8'h73; // s
                4'd3:    c = 8'h73; // s
                4'd4:    c = 8'h61; // a
                4'd5:    c = 8'h67; // g
                4'd6:    c = 8'h65; // e
                4'd7:    c = 8'h5F; // _
                4'd8:    c = 8'h6C; // l
                4'd9:    c = 8'h65; // e
                4'd10:   c = 8'h6E; // n
                4'd11:   c = 8'h67; // g
                4'd12:   c = 8'h74; // t
                4'd13:   c = 8'h68; // h
                4'd14:   c = 8'h3A; // :
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

endpackage

/* hdl/lpfe_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfe_parser
// Header hunt, decimal length parse and payload count; one byte per cycle while in_fire is high.
// ----------------------------------------------------------------------------
module lpfe_parser #(
    parameter int BUFFER_BYTES = 65536
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_fire,
    input  logic [lpfe_pkg::BYTE_W-1:0] in_byte,
    input  logic [lpfe_pkg::CFG_W-1:0]  max_len,
    output logic                        res_valid,
    output lpfe_pkg::lpfe_result_t      res
);
    import lpfe_pkg::*;

    localparam int LIM_MAX = (BUFFER_BYTES < 131071) ? BUFFER_BYTES : 131071;
    localparam int ACC_W   = $clog2(LIM_MAX + 2);
    localparam int PROD_W  = ACC_W + 4;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [HDR_CNT_W-1:0]   match_reg, match_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic [ACC_W-1:0]       rem_reg, rem_next;
    logic                   first_reg, first_next;

    logic [ACC_W-1:0]       limit;
    logic [PROD_W-1:0]      prod;
    logic [HDR_CNT_W-1:0]   cnt_cur;
    logic [HDR_CNT_W-1:0]   cnt_new;
    logic                   num_char;

    always_comb
    begin
        if (max_len > CFG_W'(LIM_MAX))
            limit = ACC_W'(LIM_MAX);
        else
            limit = ACC_W'(max_len);
    end

    assign num_char = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
    // acc * 10 + digit
    assign prod = {acc_reg, 3'b000} + PROD_W'({acc_reg, 1'b0})
                + PROD_W'(in_byte - CHAR_ZERO);

    assign cnt_cur = (match_reg >= HDR_CNT_W'(HDR_LEN)) ? '0 : match_reg;

    always_comb
    begin
        if (in_byte == hdr_char(cnt_cur))
            cnt_new = cnt_cur + 1'b1;
        else if (in_byte == hdr_char('0))
            cnt_new = HDR_CNT_W'(1);
        else
            cnt_new = '0;
    end

    always_comb
    begin
        phase_next       = phase_reg;
        match_next       = match_reg;
        acc_next         = acc_reg;
        rem_next         = rem_reg;
        first_next       = first_reg;
        res_valid        = 1'b0;
        res.payload_byte = in_byte;
        res.first_byte   = first_reg;
        res.last_byte    = (rem_reg <= ACC_W'(1));

        case (phase_reg)
            PH_DATA:
            begin
                res_valid  = in_fire;
                first_next = 1'b0;
                if (rem_reg <= ACC_W'(1))
                begin
                    phase_next = PH_HUNT;
                    match_next = '0;
                    acc_next   = '0;
                    rem_next   = '0;
                end
                else
                begin
                    rem_next = rem_reg - 1'b1;
                end
            end
            PH_LEN:
            begin
                if (num_char)
                begin
                    if (prod > PROD_W'(limit))
                        acc_next = limit + 1'b1;   // saturate
                    else
                        acc_next = prod[ACC_W-1:0];
                end
                else if (in_byte == CHAR_COLON && acc_reg != '0 && acc_reg <= limit)
                begin
                    phase_next = PH_DATA;
                    rem_next   = acc_reg;
                    first_next = 1'b1;
                    acc_next   = '0;
                    match_next = '0;
                end
                else
                begin
                    // empty, oversize or malformed length: drop and hunt
                    phase_next = PH_HUNT;
                    match_next = '0;
                    acc_next   = '0;
                    rem_next   = '0;
                    first_next = 1'b0;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
                match_next = cnt_new;
                if (cnt_new == HDR_CNT_W'(HDR_LEN))
                begin
                    phase_next = PH_LEN;
                    match_next = '0;
                    acc_next   = '0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            match_reg <= '0;
            acc_reg   <= '0;
            rem_reg   <= '0;
            first_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            match_reg <= match_next;
            acc_reg   <= acc_next;
            rem_reg   <= rem_next;
            first_reg <= first_next;
        end
    end

endmodule

/* hdl/lpfe_out_skid.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfe_out_skid
// Output register with a one-beat skid stage toward the master side.
// ----------------------------------------------------------------------------
module lpfe_out_skid (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  lpfe_pkg::lpfe_result_t      in_res,
    output logic                        in_ready,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [lpfe_pkg::BYTE_W-1:0] m_tdata,   // [7:0] payload_byte
    output logic                        m_tuser,   // [0] first_byte
    output logic                        m_tlast
);
    import lpfe_pkg::*;

    logic         main_valid_reg;
    lpfe_result_t main_reg;
    logic         skid_valid_reg;
    lpfe_result_t skid_reg;

    assign in_ready = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || m_tready)
        begin
            // drain skid first, else load straight from the parser
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= in_valid;
            end
        end
        else if (in_valid && in_ready)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
                main_reg <= skid_reg;
            else
                main_reg <= in_res;
        end
        if (in_valid && in_ready && main_valid_reg && !m_tready)
            skid_reg <= in_res;
    end

    assign m_tvalid = main_valid_reg;
    assign m_tdata  = main_reg.payload_byte;
    assign m_tuser  = main_reg.first_byte;
    assign m_tlast  = main_reg.last_byte;

endmodule

/* hdl/length_prefixed_frame_extractor_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_frame_extractor_core
// Pulls length-prefixed frames out of a byte stream.
// ----------------------------------------------------------------------------
// Every input beat is one stream byte, and the block takes one byte per clock
// while s_tready is high; the parser state registers update on each accepted
// byte. Bytes are searched for the fixed 15-byte header, followed by a decimal
// length and ':'. The next length bytes leave on the master side with tuser
// marking the first and tlast the last byte of the frame; all other bytes
// produce no beat. Lengths of zero, above the length limit register (capped at
// the smaller of BUFFER_BYTES and 131071) or broken by a non-digit drop the
// header. Each result is registered in a two-entry output stage, which keeps
// the slave side open for one beat while the master side stalls.
module length_prefixed_frame_extractor_core #(
    parameter int BUFFER_BYTES = 65536
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // slave side
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [lpfe_pkg::BYTE_W-1:0] s_tdata,   // [7:0] rx_byte
    // master side
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [lpfe_pkg::BYTE_W-1:0] m_tdata,   // [7:0] payload_byte
    output logic                        m_tuser,   // [0] first_byte
    output logic                        m_tlast,   // last_byte
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lpfe_pkg::APB_AW-1:0] paddr,
    input  logic [lpfe_pkg::APB_DW-1:0] pwdata,
    output logic [lpfe_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import lpfe_pkg::*;

    logic [CFG_W-1:0] max_len_reg;
    logic             in_fire;
    logic             res_valid;
    lpfe_result_t     res;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= MAX_LEN_RESET;
        else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_LEN)
            max_len_reg <= pwdata[CFG_W-1:0];
    end

    always_comb
    begin
        if (paddr[2] == REG_MAX_LEN)
            prdata = APB_DW'(max_len_reg);
        else
            prdata = '0;
    end

    assign in_fire = s_tvalid && s_tready;

    lpfe_parser #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_byte   (s_tdata),
        .max_len   (max_len_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    lpfe_out_skid u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (res_valid),
        .in_res   (res),
        .in_ready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    // skid stage only fills behind a held output beat
    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("slave side closed with no output beat pending");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("skid stage filled while output was not stalled");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready && m_tready |=> s_tready)
        else $error("skid stage did not drain on output handshake");
`endif

endmodule
